// ----- hw/rtl/stp_pkg.sv -----
package stp_pkg;

	// Buffer capacity in elements (1 to 64)
	localparam int MaxItems = 64;
	localparam int AddrW    = (MaxItems > 1) ? $clog2(MaxItems) : 1;
	localparam int CntW     = $clog2(MaxItems + 1);
	localparam int ValueW   = 32;
	localparam int GrpW     = 2;
	localparam int EntryW   = ValueW + GrpW;

	typedef logic [GrpW-1:0] grp_t;

	localparam grp_t GrpLess    = 2'd0;
	localparam grp_t GrpEqual   = 2'd1;
	localparam grp_t GrpGreater = 2'd2;

	// Handoff of one finished set to the scan sequencer
	typedef struct packed {
		logic [CntW-1:0] count;
		logic            dropped;
	} burst_t;

	// One candidate result from the scan sequencer
	typedef struct packed {
		logic              valid;
		logic              last;
		logic              overflow;
		logic [ValueW-1:0] value;
	} emit_t;

	function automatic grp_t classify(input logic [ValueW-1:0] a, input logic [ValueW-1:0] b);
		grp_t g;
		if ($signed(a) < $signed(b)) begin
			g = GrpLess;
		end else if (a == b) begin
			g = GrpEqual;
		end else begin
			g = GrpGreater;
		end
		return g;
	endfunction

endpackage

// ----- hw/rtl/stable_three_way_partition.sv -----
// Load: one transaction per cycle while no burst is in progress; each element is
// classified against the pivot on arrival and, while there is room, written to the RAM.
// Burst: after the last transaction the scan sequencer makes up to three passes over
// the n buffered elements, one per group (RAM read, then check for each element),
// and stops once all n elements are emitted; an output stall holds it in the check.
// Reset (arst_n low) clears pivot, counts, drop flag, sequencer and output valid.
module stable_three_way_partition (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_wr_en,
	input  logic [stp_pkg::ValueW-1:0]  cfg_wr_data,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [stp_pkg::ValueW-1:0]  value,
	input  logic                        last_in,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [stp_pkg::ValueW-1:0]  out_value,
	output logic                        last_out,
	output logic                        overflow
);
	import stp_pkg::*;

	// Pivot register; the user must write it only while the block is idle (not enforced)
	logic [ValueW-1:0] pivot_q;

	// Load-side bookkeeping for the set being collected
	logic [CntW-1:0]   count_q;
	logic              dropped_q;

	logic              in_accept;
	logic              has_room;
	logic              wr_en;
	logic [EntryW-1:0] wr_entry;
	grp_t              in_grp;

	burst_t            burst;
	logic              start;
	logic              scan_busy;

	logic              rd_en;
	logic [AddrW-1:0]  rd_addr;
	logic [EntryW-1:0] rd_data;

	emit_t             emit;
	logic              emit_take;

	// Output register
	logic              out_valid_q;
	logic [ValueW-1:0] out_value_q;
	logic              last_out_q;
	logic              overflow_q;

	// Accept input only while the scan sequencer is idle
	assign in_ready  = !scan_busy;
	assign in_accept = in_valid && in_ready;
	assign has_room  = (count_q < CntW'(MaxItems));

	// Classify on arrival; group rides along with the value in the RAM entry
	assign in_grp   = classify(value, pivot_q);
	assign wr_en    = in_accept && has_room;
	assign wr_entry = {in_grp, value};

	// Hand the complete set to the sequencer, counting this transaction
	assign start         = in_accept && last_in;
	assign burst.count   = has_room ? (count_q + CntW'(1)) : count_q;
	assign burst.dropped = dropped_q || !has_room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pivot_q <= '0;
		end else if (cfg_wr_en) begin
			pivot_q <= cfg_wr_data;
		end
	end

	// Advance the fill count, note drops, restart after each set
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			dropped_q <= 1'b0;
		end else if (in_accept) begin
			if (last_in) begin
				count_q   <= '0;
				dropped_q <= 1'b0;
			end else if (has_room) begin
				count_q <= count_q + CntW'(1);
			end else begin
				dropped_q <= 1'b1;
			end
		end
	end

	stp_ram #(
		.Width (EntryW),
		.Depth (MaxItems)
	) u_store (
		.clk   (clk),
		.we    (wr_en),
		.waddr (count_q[AddrW-1:0]),
		.wdata (wr_entry),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	stp_scan u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.burst     (burst),
		.busy      (scan_busy),
		.rd_en     (rd_en),
		.rd_addr   (rd_addr),
		.rd_data   (rd_data),
		.emit      (emit),
		.emit_take (emit_take)
	);

	// Load the output register when it is empty or being drained this cycle
	assign emit_take = emit.valid && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_take) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Payload holds while a transaction waits
	always_ff @(posedge clk) begin
		if (emit_take) begin
			out_value_q <= emit.value;
			last_out_q  <= emit.last;
			overflow_q  <= emit.overflow;
		end
	end

	assign out_valid = out_valid_q;
	assign out_value = out_value_q;
	assign last_out  = last_out_q;
	assign overflow  = overflow_q;

	// Fill count never passes the buffer capacity
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CntW'(MaxItems))
		else $error("fill count beyond capacity");

	// A set handoff always starts the sequencer
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> scan_busy)
		else $error("sequencer did not start on last transaction");

	// No candidate result while the load side is open
	a_no_emit_on_load: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !emit.valid)
		else $error("scan emitted while accepting input");

	// The output register is only loaded when its slot is free
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready) |-> !emit_take)
		else $error("output register overwritten while stalled");

endmodule

// ----- hw/rtl/stp_ram.sv -----
module stp_ram #(
	parameter int Width = 32,
	parameter int Depth = 64
) (
	input  logic                                        clk,
	input  logic                                        we,
	input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr,
	input  logic [Width-1:0]                            wdata,
	input  logic                                        re,
	input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr,
	output logic [Width-1:0]                            rdata
);

	logic [Width-1:0] mem_q [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ----- hw/rtl/stp_scan.sv -----
module stp_scan (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  stp_pkg::burst_t               burst,
	output logic                          busy,
	output logic                          rd_en,
	output logic [stp_pkg::AddrW-1:0]     rd_addr,
	input  logic [stp_pkg::EntryW-1:0]    rd_data,
	output stp_pkg::emit_t                emit,
	input  logic                          emit_take
);
	import stp_pkg::*;

	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_READ  = 2'd1;
	localparam logic [1:0] S_CHECK = 2'd2;

	logic [1:0]      state_q;
	logic [CntW-1:0] idx_q;
	logic [CntW-1:0] pos_q;
	logic [CntW-1:0] n_q;
	grp_t            grp_q;
	logic            drop_q;

	logic            match;
	logic            is_final;
	logic            advance;
	logic [CntW-1:0] idx_nxt;
	logic [CntW-1:0] pos_nxt;

	assign match    = (state_q == S_CHECK) && (rd_data[EntryW-1 -: GrpW] == grp_q);
	assign pos_nxt  = pos_q + CntW'(1);
	assign idx_nxt  = idx_q + CntW'(1);
	assign is_final = (pos_nxt == n_q);
	assign advance  = (state_q == S_CHECK) && (!match || emit_take);

	assign busy    = (state_q != S_IDLE);
	assign rd_en   = (state_q == S_READ);
	assign rd_addr = idx_q[AddrW-1:0];

	always_comb begin
		emit.valid    = match;
		emit.last     = is_final;
		emit.overflow = drop_q;
		emit.value    = rd_data[ValueW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			idx_q   <= '0;
			pos_q   <= '0;
			n_q     <= '0;
			grp_q   <= GrpLess;
			drop_q  <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						n_q     <= burst.count;
						drop_q  <= burst.dropped;
						idx_q   <= '0;
						pos_q   <= '0;
						grp_q   <= GrpLess;
						state_q <= S_READ;
					end
				end
				S_READ: begin
					state_q <= S_CHECK;
				end
				S_CHECK: begin
					if (advance) begin
						if (match) begin
							pos_q <= pos_nxt;
						end
						if (match && is_final) begin
							state_q <= S_IDLE;
						end else if (idx_nxt >= n_q) begin
							idx_q <= '0;
							if (grp_q == GrpGreater) begin
								state_q <= S_IDLE;
							end else begin
								grp_q   <= grp_q + grp_t'(1);
								state_q <= S_READ;
							end
						end else begin
							idx_q   <= idx_nxt;
							state_q <= S_READ;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule
